### rtl/scc_clp_pkg.sv
package scc_clp_pkg;

  localparam int NODE_W        = 9;
  localparam int CHAIN_W       = 8;
  localparam int DEF_MAX_NODES = 256;
  localparam int DEF_MAX_EDGES = 1024;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE,
    S_CLR,
    S_CNT_RD,
    S_CNT_LS,
    S_CNT_WR,
    S_PRE_RD,
    S_PRE_WR,
    S_FIL_RD,
    S_FIL_FP,
    S_FIL_WR,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_VISIT,
    S_VIS_A,
    S_VIS_B,
    S_WALK,
    S_EDGE,
    S_EDGE_CHK,
    S_POP,
    S_CMP_RD,
    S_CMP_WR,
    S_CH_NODE,
    S_CH_LO,
    S_CH_HI,
    S_CH_END,
    S_CH_EDGE,
    S_CH_TGT,
    S_CH_CID,
    S_CH_LEN,
    S_PAR_RD,
    S_PAR_A,
    S_PAR_B,
    S_OUT
  } state_t;

endpackage

### rtl/scc_condensed_longest_path_core.sv
// an edge request is stored, or dropped, while idle; a run request clears the marks and
// builds the lists, then does the component search and the chain pass
// throughput: one request at a time, as s_tready is high only in S_IDLE
// reset: rst (synchronous) empties the edge store, clears the drop flag and
// sets node_count to 256; memory contents are not cleared
module scc_condensed_longest_path_core
  import scc_clp_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [8:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // from_node [8:0], to_node [17:9], zeros
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // longest_chain [7:0], edges_dropped [8], zeros
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int CW  = NIW + 1;
  localparam int XW  = (CW > NODE_W) ? CW : NODE_W;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  state_t state, state_next;

  logic [NODE_W-1:0] node_count;
  logic [CW-1:0]     n;
  logic [EW-1:0]     etot;
  logic              drop;
  logic [CHAIN_W-1:0] out_chain;
  logic              out_drop;

  logic [CW-1:0]  u, r, i, j, base, nsp, wsp, clen, best;
  logic [EW-1:0]  e, acc, pos, aend;
  logic [NIW-1:0] s, t, x, a, alow, avo, clow, stamp, comps;

  // memories
  logic [NIW-1:0] esrc_mem [MAX_EDGES];
  logic [NIW-1:0] etgt_mem [MAX_EDGES];
  logic [EW-1:0]  ls_mem   [MAX_NODES+1];
  logic [EW-1:0]  fill_mem [MAX_NODES];
  logic [NIW-1:0] srt_mem  [MAX_EDGES];
  logic           vis_mem  [MAX_NODES];
  logic           ons_mem  [MAX_NODES];
  logic [NIW-1:0] vo_mem   [MAX_NODES];
  logic [NIW-1:0] ll_mem   [MAX_NODES];
  logic [NIW-1:0] cid_mem  [MAX_NODES];
  logic [NIW-1:0] nstk_mem [MAX_NODES];
  logic [NIW-1:0] wn_mem   [MAX_NODES];
  logic [EW-1:0]  wp_mem   [MAX_NODES];
  logic [CW-1:0]  ch_mem   [MAX_NODES];

  logic [NIW-1:0] esrc_q, etgt_q, srt_q, vo_q, ll_q, cid_q, nstk_q, wn_q;
  logic [EW-1:0]  ls_q, fill_q, wp_q;
  logic           vis_q, ons_q;
  logic [CW-1:0]  ch_q;

  logic           e_we;
  logic [EAW-1:0] e_wa, e_ra;
  logic           ls_we;
  logic [CW-1:0]  ls_wa, ls_ra;
  logic [EW-1:0]  ls_wd;
  logic           fill_we;
  logic [NIW-1:0] fill_wa, fill_ra;
  logic [EW-1:0]  fill_wd;
  logic           srt_we;
  logic [EAW-1:0] srt_wa, srt_ra;
  logic           vis_we, vis_wd;
  logic [NIW-1:0] vis_wa, vis_ra;
  logic           ons_we, ons_wd;
  logic [NIW-1:0] ons_wa, ons_ra;
  logic           vo_we;
  logic [NIW-1:0] vo_ra, ll_ra;
  logic           ll_we;
  logic           cid_we;
  logic [NIW-1:0] cid_wa, cid_ra;
  logic           nstk_we;
  logic [NIW-1:0] nstk_ra;
  logic           wn_we, wp_we;
  logic [NIW-1:0] w_ra;
  logic           ch_we;
  logic [NIW-1:0] ch_ra;

  logic [XW-1:0]  src_x, dst_x, n_x, best_x;
  logic           edge_bad, s_hs, out_free;
  logic [EW-1:0]  cum;

  assign src_x    = XW'(s_tdata[8:0]);
  assign dst_x    = XW'(s_tdata[17:9]);
  assign n_x      = XW'(n);
  assign best_x   = XW'(best);
  assign edge_bad = (src_x == '0) || (dst_x == '0) || (src_x > n_x) || (dst_x > n_x)
                    || (etot == EW'(MAX_EDGES));
  assign s_tready = (state == S_IDLE);
  assign s_hs     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cum      = acc + ls_q;
  assign m_tdata  = {7'd0, out_drop, out_chain};

  always_comb begin
    if (XW'(node_count) > XW'(MAX_NODES)) begin
      n = CW'(MAX_NODES);
    end else begin
      n = CW'(node_count);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_hs && s_tuser == OP_RUN) begin
          state_next = (n == '0) ? S_OUT : S_CLR;
        end
      end
      S_CLR:      state_next = (u == n) ? S_CNT_RD : S_CLR;
      S_CNT_RD:   state_next = (e == etot) ? S_PRE_RD : S_CNT_LS;
      S_CNT_LS:   state_next = ({1'b0, esrc_q} < n) ? S_CNT_WR : S_CNT_RD;
      S_CNT_WR:   state_next = S_CNT_RD;
      S_PRE_RD:   state_next = S_PRE_WR;
      S_PRE_WR:   state_next = (u == n) ? S_FIL_RD : S_PRE_RD;
      S_FIL_RD:   state_next = (e == etot) ? S_ROOT_RD : S_FIL_FP;
      S_FIL_FP:   state_next = ({1'b0, esrc_q} < n) ? S_FIL_WR : S_FIL_RD;
      S_FIL_WR:   state_next = S_FIL_RD;
      S_ROOT_RD:  state_next = (r == n) ? S_OUT : S_ROOT_CHK;
      S_ROOT_CHK: state_next = vis_q ? S_ROOT_RD : S_VISIT;
      S_VISIT:    state_next = S_VIS_A;
      S_VIS_A:    state_next = S_VIS_B;
      S_VIS_B:    state_next = S_WALK;
      S_WALK:     state_next = (pos < aend) ? S_EDGE : S_POP;
      S_EDGE:     state_next = ({1'b0, srt_q} >= n) ? S_WALK : S_EDGE_CHK;
      S_EDGE_CHK: state_next = vis_q ? S_WALK : S_VISIT;
      S_POP: begin
        if (alow == avo) begin
          state_next = S_CMP_RD;
        end else if (wsp == CW'(1)) begin
          state_next = S_ROOT_RD;
        end else begin
          state_next = S_PAR_RD;
        end
      end
      S_CMP_RD:   state_next = S_CMP_WR;
      S_CMP_WR:   state_next = (nstk_q == a) ? S_CH_NODE : S_CMP_RD;
      S_CH_NODE: begin
        if (j != nsp) begin
          state_next = S_CH_LO;
        end else if (wsp == '0) begin
          state_next = S_ROOT_RD;
        end else begin
          state_next = S_PAR_RD;
        end
      end
      S_CH_LO:    state_next = S_CH_HI;
      S_CH_HI:    state_next = S_CH_END;
      S_CH_END:   state_next = S_CH_EDGE;
      S_CH_EDGE:  state_next = (pos < aend) ? S_CH_TGT : S_CH_NODE;
      S_CH_TGT:   state_next = ({1'b0, srt_q} < n) ? S_CH_CID : S_CH_EDGE;
      S_CH_CID:   state_next = (cid_q == comps) ? S_CH_EDGE : S_CH_LEN;
      S_CH_LEN:   state_next = S_CH_EDGE;
      S_PAR_RD:   state_next = S_PAR_A;
      S_PAR_A:    state_next = S_PAR_B;
      S_PAR_B:    state_next = S_WALK;
      S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    e_we    = 1'b0;
    e_wa    = etot[EAW-1:0];
    e_ra    = e[EAW-1:0];
    ls_we   = 1'b0;
    ls_wa   = u;
    ls_wd   = '0;
    ls_ra   = u;
    fill_we = 1'b0;
    fill_wa = u[NIW-1:0];
    fill_wd = cum;
    fill_ra = esrc_q;
    srt_we  = 1'b0;
    srt_wa  = fill_q[EAW-1:0];
    srt_ra  = pos[EAW-1:0];
    vis_we  = 1'b0;
    vis_wa  = u[NIW-1:0];
    vis_wd  = 1'b0;
    vis_ra  = srt_q;
    ons_we  = 1'b0;
    ons_wa  = u[NIW-1:0];
    ons_wd  = 1'b0;
    ons_ra  = srt_q;
    vo_we   = 1'b0;
    vo_ra   = srt_q;
    ll_we   = 1'b0;
    ll_ra   = wn_q;
    cid_we  = 1'b0;
    cid_wa  = nstk_q;
    cid_ra  = srt_q;
    nstk_we = 1'b0;
    nstk_ra = i[NIW-1:0];
    wn_we   = 1'b0;
    wp_we   = 1'b0;
    w_ra    = NIW'(wsp - CW'(1));
    ch_we   = 1'b0;
    ch_ra   = cid_q;
    unique case (state)
      S_IDLE: begin
        e_we = s_hs && (s_tuser == OP_EDGE) && !edge_bad;
      end
      S_CLR: begin
        ls_we  = 1'b1;
        vis_we = (u < n);
        ons_we = (u < n);
      end
      S_CNT_LS: begin
        ls_ra = CW'(esrc_q) + CW'(1);
      end
      S_CNT_WR: begin
        ls_we = 1'b1;
        ls_wa = CW'(s) + CW'(1);
        ls_wd = ls_q + EW'(1);
      end
      S_PRE_WR: begin
        ls_we   = 1'b1;
        ls_wd   = cum;
        fill_we = (u < n);
      end
      S_FIL_WR: begin
        srt_we  = 1'b1;
        fill_we = 1'b1;
        fill_wa = s;
        fill_wd = fill_q + EW'(1);
      end
      S_ROOT_RD: begin
        vis_ra = r[NIW-1:0];
      end
      S_VISIT: begin
        vis_we  = 1'b1;
        vis_wa  = x;
        vis_wd  = 1'b1;
        ons_we  = 1'b1;
        ons_wa  = x;
        ons_wd  = 1'b1;
        vo_we   = 1'b1;
        nstk_we = 1'b1;
        wn_we   = 1'b1;
        wp_we   = (wsp != '0);
        ll_we   = (wsp != '0);
        ls_ra   = CW'(x);
      end
      S_VIS_A: begin
        ls_ra = CW'(x) + CW'(1);
      end
      S_CMP_WR: begin
        cid_we = 1'b1;
        ons_we = 1'b1;
        ons_wa = nstk_q;
      end
      S_CH_NODE: begin
        nstk_ra = j[NIW-1:0];
        ch_we   = (j == nsp);
      end
      S_CH_LO: begin
        ls_ra = CW'(nstk_q);
      end
      S_CH_HI: begin
        ls_ra = CW'(x) + CW'(1);
      end
      S_PAR_A: begin
        ls_ra = CW'(wn_q) + CW'(1);
        vo_ra = wn_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      esrc_mem[e_wa] <= NIW'(s_tdata[8:0] - 9'd1);
      etgt_mem[e_wa] <= NIW'(s_tdata[17:9] - 9'd1);
    end
    esrc_q <= esrc_mem[e_ra];
    etgt_q <= etgt_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_wa] <= ls_wd;
    end
    ls_q <= ls_mem[ls_ra];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    fill_q <= fill_mem[fill_ra];
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_wa] <= t;
    end
    srt_q <= srt_mem[srt_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (ons_we) begin
      ons_mem[ons_wa] <= ons_wd;
    end
    ons_q <= ons_mem[ons_ra];
  end

  always_ff @(posedge clk) begin
    if (vo_we) begin
      vo_mem[x] <= stamp;
    end
    vo_q <= vo_mem[vo_ra];
  end

  always_ff @(posedge clk) begin
    if (ll_we) begin
      ll_mem[a] <= alow;
    end
    ll_q <= ll_mem[ll_ra];
  end

  always_ff @(posedge clk) begin
    if (cid_we) begin
      cid_mem[cid_wa] <= comps;
    end
    cid_q <= cid_mem[cid_ra];
  end

  always_ff @(posedge clk) begin
    if (nstk_we) begin
      nstk_mem[nsp[NIW-1:0]] <= x;
    end
    nstk_q <= nstk_mem[nstk_ra];
  end

  always_ff @(posedge clk) begin
    if (wn_we) begin
      wn_mem[wsp[NIW-1:0]] <= x;
    end
    if (wp_we) begin
      wp_mem[w_ra] <= pos;
    end
    wn_q <= wn_mem[w_ra];
    wp_q <= wp_mem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[comps] <= clen;
    end
    ch_q <= ch_mem[ch_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= 9'd256;
      etot       <= '0;
      drop       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        node_count <= cfg_wdata;
      end
      if (state == S_IDLE && s_hs && s_tuser == OP_EDGE) begin
        if (edge_bad) begin
          drop <= 1'b1;
        end else begin
          etot <= etot + EW'(1);
        end
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
        etot     <= '0;
        drop     <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        u     <= '0;
        e     <= '0;
        acc   <= '0;
        r     <= '0;
        stamp <= '0;
        comps <= '0;
        nsp   <= '0;
        wsp   <= '0;
        best  <= '0;
      end
      S_CLR: begin
        u <= (u == n) ? '0 : u + CW'(1);
      end
      S_CNT_RD: begin
        if (e == etot) begin
          e <= '0;
        end
      end
      S_CNT_LS: begin
        s <= esrc_q;
        if ({1'b0, esrc_q} >= n) begin
          e <= e + EW'(1);
        end
      end
      S_CNT_WR: begin
        e <= e + EW'(1);
      end
      S_PRE_WR: begin
        acc <= cum;
        u   <= u + CW'(1);
      end
      S_FIL_FP: begin
        s <= esrc_q;
        t <= etgt_q;
        if ({1'b0, esrc_q} >= n) begin
          e <= e + EW'(1);
        end
      end
      S_FIL_WR: begin
        e <= e + EW'(1);
      end
      S_ROOT_CHK: begin
        if (vis_q) begin
          r <= r + CW'(1);
        end
        x <= r[NIW-1:0];
      end
      S_VISIT: begin
        nsp <= nsp + CW'(1);
      end
      S_VIS_A: begin
        pos <= ls_q;
      end
      S_VIS_B: begin
        aend  <= ls_q;
        a     <= x;
        alow  <= stamp;
        avo   <= stamp;
        stamp <= stamp + NIW'(1);
        wsp   <= wsp + CW'(1);
      end
      S_WALK: begin
        if (pos < aend) begin
          pos <= pos + EW'(1);
        end
      end
      S_EDGE: begin
        x <= srt_q;
      end
      S_EDGE_CHK: begin
        if (vis_q && ons_q && vo_q < alow) begin
          alow <= vo_q;
        end
      end
      S_POP: begin
        wsp  <= wsp - CW'(1);
        clow <= alow;
        i    <= nsp - CW'(1);
        if (alow != avo && wsp == CW'(1)) begin
          r <= r + CW'(1);
        end
      end
      S_CMP_WR: begin
        if (nstk_q == a) begin
          base <= i;
          j    <= i;
          clen <= '0;
        end else begin
          i <= i - CW'(1);
        end
      end
      S_CH_NODE: begin
        if (j == nsp) begin
          if (clen > best) begin
            best <= clen;
          end
          comps <= comps + NIW'(1);
          nsp   <= base;
          if (wsp == '0) begin
            r <= r + CW'(1);
          end
        end
      end
      S_CH_LO: begin
        x <= nstk_q;
      end
      S_CH_HI: begin
        pos <= ls_q;
      end
      S_CH_END: begin
        aend <= ls_q;
      end
      S_CH_EDGE: begin
        if (pos < aend) begin
          pos <= pos + EW'(1);
        end else begin
          j <= j + CW'(1);
        end
      end
      S_CH_LEN: begin
        if (ch_q + CW'(1) > clen) begin
          clen <= ch_q + CW'(1);
        end
      end
      S_PAR_A: begin
        a   <= wn_q;
        pos <= wp_q;
      end
      S_PAR_B: begin
        alow <= (ll_q < clow) ? ll_q : clow;
        avo  <= vo_q;
        aend <= ls_q;
      end
      S_OUT: begin
        if (out_free) begin
          out_chain <= (best_x > XW'(255)) ? 8'hFF : best_x[7:0];
          out_drop  <= drop;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_walk_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (wsp != '0))
    else $error("walk with empty frame stack");

  a_stack_depth: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (nsp >= wsp))
    else $error("node stack shallower than walk stack");

  a_store_emptied: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (m_tvalid && etot == '0 && !drop))
    else $error("edge store not emptied after run");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP_WR) |-> (nsp != '0))
    else $error("component pop from empty stack");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import scc_clp_pkg::*;

  localparam int NMAX = DEF_MAX_NODES;
  localparam int EMAX = DEF_MAX_EDGES;
  localparam int LIMIT = 8000000;

  typedef struct packed {
    logic [7:0] chain;
    logic       dropped;
  } chain_result_t;

  // scoreboard: keeps its own edge store and answers each run request
  class chain_scoreboard;
    int unsigned src_q[$];
    int unsigned dst_q[$];
    bit          dropped;
    int unsigned nodes;
    chain_result_t pending[$];
    int errors;
    int runs;

    function new();
      nodes = 256;
      errors = 0;
      runs = 0;
      dropped = 0;
    endfunction

    function int unsigned longest_chain();
      int unsigned n, best, stamp, ncomp, nsp, wsp, cur, a, v, base, c, m, p, t;
      int unsigned lstart[NMAX+1];
      int unsigned fillp[NMAX];
      int unsigned tgt[EMAX];
      int unsigned order[NMAX], lowl[NMAX], cid[NMAX], clen[NMAX];
      int unsigned nstk[NMAX], wnode[NMAX], wpos[NMAX];
      bit vis[NMAX], onst[NMAX];
      n = nodes > NMAX ? NMAX : nodes;
      best = 0; stamp = 0; ncomp = 0; nsp = 0; wsp = 0;
      if (n == 0) return 0;
      for (int i = 0; i <= NMAX; i++) lstart[i] = 0;
      foreach (src_q[e]) if (src_q[e] < n) lstart[src_q[e] + 1]++;
      for (int u = 0; u < n; u++) lstart[u + 1] += lstart[u];
      for (int u = 0; u < n; u++) begin
        fillp[u] = lstart[u];
        vis[u] = 0;
        onst[u] = 0;
      end
      foreach (src_q[e]) if (src_q[e] < n) tgt[fillp[src_q[e]]++] = dst_q[e];
      for (int r = 0; r < n; r++) begin
        if (vis[r]) continue;
        vis[r] = 1;
        order[r] = stamp; lowl[r] = stamp; stamp++;
        nstk[nsp++] = r; onst[r] = 1;
        wnode[wsp] = r; wpos[wsp] = lstart[r]; wsp++;
        while (wsp > 0) begin
          cur = wsp - 1;
          a = wnode[cur];
          if (wpos[cur] < lstart[a + 1]) begin
            v = tgt[wpos[cur]];
            wpos[cur]++;
            if (v >= n) continue;
            if (!vis[v]) begin
              vis[v] = 1;
              order[v] = stamp; lowl[v] = stamp; stamp++;
              nstk[nsp++] = v; onst[v] = 1;
              wnode[wsp] = v; wpos[wsp] = lstart[v]; wsp++;
            end else if (onst[v] && order[v] < lowl[a]) begin
              lowl[a] = order[v];
            end
            continue;
          end
          wsp--;
          if (lowl[a] == order[a]) begin
            base = nsp;
            c = ncomp++;
            do base--; while (nstk[base] != a);
            for (int i = base; i < nsp; i++) begin
              cid[nstk[i]] = c;
              onst[nstk[i]] = 0;
            end
            clen[c] = 0;
            for (int i = base; i < nsp; i++) begin
              m = nstk[i];
              for (int k = lstart[m]; k < lstart[m + 1]; k++) begin
                t = tgt[k];
                if (t >= n || cid[t] == c) continue;
                if (clen[cid[t]] + 1 > clen[c]) clen[c] = clen[cid[t]] + 1;
              end
            end
            if (clen[c] > best) best = clen[c];
            nsp = base;
          end
          if (wsp > 0) begin
            p = wnode[wsp - 1];
            if (lowl[a] < lowl[p]) lowl[p] = lowl[a];
          end
        end
      end
      return best > 255 ? 255 : best;
    endfunction

    function void note_request(logic op, logic [8:0] from_n, logic [8:0] to_n);
      int unsigned n;
      chain_result_t r;
      n = nodes > NMAX ? NMAX : nodes;
      if (op == OP_EDGE) begin
        if (from_n == 0 || to_n == 0 || from_n > n || to_n > n || src_q.size() >= EMAX)
          dropped = 1;
        else begin
          src_q = {src_q, 32'(from_n) - 32'd1};
          dst_q = {dst_q, 32'(to_n) - 32'd1};
        end
      end else begin
        r.chain = 8'(longest_chain());
        r.dropped = dropped;
        pending = {pending, r};
        src_q.delete();
        dst_q.delete();
        dropped = 0;
      end
    endfunction

    function void check_result(logic [15:0] data);
      chain_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      runs++;
      if (data[7:0] !== e.chain) begin
        $error("longest_chain expected %0d actual %0d", e.chain, data[7:0]);
        errors++;
      end
      if (data[8] !== e.dropped) begin
        $error("edges_dropped expected %0d actual %0d", e.dropped, data[8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wen = 0;
  logic [8:0]  cfg_wdata = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = 0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;

  chain_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int rx_hold = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  scc_condensed_longest_path_core dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 0;
    end else if ($urandom_range(0, 9) < 3) begin
      rx_hold <= gap_len();
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  task automatic send(logic op, logic [8:0] from_n, logic [8:0] to_n);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {6'd0, to_n, from_n};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, from_n, to_n);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_nodes(int unsigned v);
    drain();
    @(negedge clk);
    cfg_wen <= 1;
    cfg_wdata <= 9'(v);
    @(negedge clk);
    cfg_wen <= 0;
    sb.nodes = v;
  endtask

  // random graph: well-formed edges mostly, chains and cycles mixed in
  task automatic random_graph(int unsigned n, int edges);
    int unsigned a, b;
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send(OP_EDGE, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      end else if ($urandom_range(0, 2) == 0) begin
        a = $urandom_range(1, n);
        b = (a < n) ? a + 1 : 1;
        send(OP_EDGE, 9'(a), 9'(b));
      end else begin
        send(OP_EDGE, 9'($urandom_range(1, n)), 9'($urandom_range(1, n)));
      end
    end
    send(OP_RUN, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty run, extremes, dropped edges, cycle collapse
    send(OP_RUN, 0, 0);
    send(OP_EDGE, 1, 256);
    send(OP_EDGE, 256, 1);
    send(OP_EDGE, 0, 5);
    send(OP_EDGE, 5, 0);
    send(OP_RUN, 9'h1ff, 9'h1ff);
    send(OP_EDGE, 1, 2);
    send(OP_EDGE, 2, 3);
    send(OP_EDGE, 3, 4);
    send(OP_EDGE, 4, 2);
    send(OP_EDGE, 3, 3);
    send(OP_EDGE, 4, 5);
    send(OP_EDGE, 257, 2);
    send(OP_RUN, 0, 0);
    set_nodes(0);
    send(OP_EDGE, 1, 1);
    send(OP_RUN, 0, 0);
    set_nodes(511);
    send(OP_EDGE, 256, 255);
    send(OP_EDGE, 300, 1);
    send(OP_RUN, 0, 0);
    // node count lowered after loading
    set_nodes(8);
    send(OP_EDGE, 7, 8);
    send(OP_EDGE, 8, 1);
    set_nodes(7);
    send(OP_RUN, 0, 0);

    // long chain up to the 8-bit maximum, plus store overflow
    set_nodes(256);
    for (int i = 1; i < 256; i++) send(OP_EDGE, 9'(i), 9'(i + 1));
    send(OP_RUN, 0, 0);
    for (int i = 0; i < 1030; i++)
      send(OP_EDGE, 9'($urandom_range(1, 4)), 9'($urandom_range(1, 4)));
    send(OP_RUN, 0, 0);

    set_nodes(1);
    random_graph(1, 4);
    while (sent < 1525) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 9) == 0 ? $urandom_range(200, 511) : $urandom_range(1, 16);
        set_nodes(n);
      end
      n = sb.nodes > NMAX ? NMAX : sb.nodes;
      if (n == 0) n = 1;
      random_graph(n, $urandom_range(0, 30));
    end
    set_nodes(256);
    random_graph(256, 20);

    drain();
    $display("ran %0d requests, %0d analysis results checked", sent, sb.runs);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
